/* src/pdtsc_pkg.sv */
// Package for the pushdown token syntax checker.
// Holds the transition ROM, the status and finish codes, and the shared types.
// No dependencies.
`default_nettype none

package pdtsc_pkg;

   localparam int DEF_STACK_DEPTH       = 16;
   localparam int DEF_MAX_EPSILON_STEPS = 16;

   localparam int TOKEN_W  = 7;
   localparam int STATE_W  = 7;
   localparam int STATUS_W = 3;
   localparam int DEPTH_W  = 5;

   localparam int ROM_SIZE  = 70;
   localparam int ROM_IDX_W = $clog2(ROM_SIZE);

   localparam int ANY  = 255;
   localparam int EXIT = 0;

   localparam logic [7:0]         ANY_TOKEN   = 8'hFF;
   localparam logic [STATE_W-1:0] EXIT_MOVE   = '0;
   localparam logic [STATE_W-1:0] NO_RETURN   = '0;
   localparam logic [STATE_W-1:0] START_STATE = 7'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_CONSUMED = 3'd0,
      ST_ACCEPTED = 3'd1,
      ST_SYNTAX   = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_IGNORED  = 3'd4,
      ST_STEPS    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FIN_RUNNING  = 2'd0,
      FIN_ACCEPTED = 2'd1,
      FIN_STOPPED  = 2'd2
   } finish_type;

   typedef enum logic [4:0] {
      FSM_IDLE = 5'b00001,
      FSM_SCAN = 5'b00010,
      FSM_POP  = 5'b00100,
      FSM_LOAD = 5'b01000,
      FSM_EMIT = 5'b10000
   } fsm_type;

   typedef struct packed {
      logic [STATE_W-1:0] src_state;
      logic [STATE_W-1:0] dst_state;
      logic [7:0]         tok;
      logic [STATE_W-1:0] ret_state;
   } rom_entry_type;

   typedef struct packed {
      logic          done;
      logic          hit;
      rom_entry_type entry;
   } scan_res_type;

   function automatic rom_entry_type mk(input int f, input int t, input int k, input int r);
      rom_entry_type e;
      e.src_state = STATE_W'(f);
      e.dst_state = STATE_W'(t);
      e.tok       = 8'(k);
      e.ret_state = STATE_W'(r);
      return e;
   endfunction

   localparam rom_entry_type ROM_TABLE [ROM_SIZE] = '{
      mk(1, 2, 1, 0),      mk(1, 2, 2, 0),      mk(2, 3, 100, 0),    mk(3, 2, 14, 0),
      mk(3, 1, 13, 0),     mk(3, 4, 11, 0),     mk(4, 10, 13, 5),    mk(5, 6, 12, 0),
      mk(6, EXIT, ANY, 0),
      mk(10, 11, 102, 0),  mk(10, 20, ANY, 12), mk(11, 20, 31, 12),
      mk(12, 13, 13, 0),   mk(13, 14, 102, 0),  mk(13, EXIT, 12, 0),
      mk(13, EXIT, 7, 0),  mk(13, 20, ANY, 12), mk(14, 20, 31, 12),
      mk(20, 21, 100, 0),  mk(20, 23, 9, 0),    mk(20, 26, 10, 0),   mk(20, 29, 3, 0),
      mk(20, 39, 8, 0),    mk(20, 45, 30, 0),
      mk(21, 50, 17, 22),  mk(22, EXIT, ANY, 0),
      mk(23, 24, 15, 0),   mk(24, 25, 100, 0),  mk(25, 24, 15, 0),
      mk(25, EXIT, ANY, 0),
      mk(26, 27, 16, 0),   mk(27, 28, 100, 0),  mk(28, 27, 16, 0),
      mk(28, EXIT, ANY, 0),
      mk(29, 30, 100, 0),  mk(30, 50, 17, 31),  mk(31, 50, 4, 32),   mk(32, 50, 5, 33),
      mk(33, 34, 6, 0),    mk(34, 60, 28, 35),  mk(35, 36, 29, 0),   mk(36, 10, 13, 37),
      mk(37, 38, 7, 0),    mk(38, EXIT, ANY, 0),
      mk(39, 60, 28, 40),  mk(40, 41, 29, 0),   mk(41, 42, 11, 0),   mk(42, 10, 13, 43),
      mk(43, 44, 12, 0),   mk(44, EXIT, ANY, 0),
      mk(45, 46, 102, 0),  mk(46, EXIT, ANY, 0),
      mk(50, 50, 25, 0),   mk(50, 51, 100, 0),  mk(50, 51, 101, 0),  mk(50, 50, 28, 52),
      mk(51, 50, 24, 0),   mk(51, 50, 25, 0),   mk(51, 50, 26, 0),   mk(51, 50, 27, 0),
      mk(51, EXIT, ANY, 0), mk(52, 51, 29, 0),
      mk(60, 50, ANY, 61), mk(61, 50, 20, 62),  mk(61, 50, 18, 62),
      mk(61, 50, 19, 62),  mk(61, 50, 21, 62),  mk(61, 50, 22, 62),  mk(61, 50, 23, 62),
      mk(62, EXIT, ANY, 0)
   };

endpackage

`default_nettype wire

/* src/pushdown_token_syntax_checker.sv */
// Top level of the pushdown token syntax checker: sequencer, state, result register.
// Depends on pdtsc_pkg, pdtsc_scan and pdtsc_stack.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_token_class, req_new_program
//   rsp     | out       | rsp_valid, rsp_stall, rsp_status, rsp_state_after, rsp_stack_depth
//
// One item at a time; req_stall is low only when the sequencer is idle.
// Each move scans the ROM on the shared comparator from the first entry up to the match,
// and each pop passes through the pop and load states; an item makes at most
// MAX_EPSILON_STEPS moves. Ignored items go straight to the emit state.
// Reset sets state 1, empty stack and running; the stack memory needs no clearing.
// A result waits in the output register while rsp_stall is high; a new item is taken meanwhile.
`default_nettype none

module pushdown_token_syntax_checker #(
   parameter int STACK_DEPTH       = pdtsc_pkg::DEF_STACK_DEPTH,
   parameter int MAX_EPSILON_STEPS = pdtsc_pkg::DEF_MAX_EPSILON_STEPS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [pdtsc_pkg::TOKEN_W-1:0]  req_token_class,
   input  wire logic                           req_new_program,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic      [pdtsc_pkg::STATUS_W-1:0] rsp_status,
   output logic      [pdtsc_pkg::STATE_W-1:0]  rsp_state_after,
   output logic      [pdtsc_pkg::DEPTH_W-1:0]  rsp_stack_depth
);
   import pdtsc_pkg::*;

   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int STEP_W = $clog2(MAX_EPSILON_STEPS);

   fsm_type            fsm_ff, fsm_in;
   logic [STATE_W-1:0] cur_ff, cur_in;
   logic [SP_W-1:0]    sp_ff, sp_in;
   finish_type         flag_ff, flag_in;
   logic [TOKEN_W-1:0] tok_ff, tok_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   status_type         status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;

   scan_res_type       res;
   logic               scan_start;
   logic               stk_wr_en;
   logic [STATE_W-1:0] stk_rd_data;
   logic               push;
   logic [SP_W-1:0]    sp_next;
   logic               advance;
   finish_type         flag_eff;

   pdtsc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (scan_start),
      .cur_state (cur_ff),
      .token     (tok_ff),
      .res       (res)
   );

   pdtsc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (sp_ff[ADDR_W-1:0]),
      .wr_data (res.entry.ret_state),
      .rd_addr (sp_ff[ADDR_W-1:0]),
      .rd_data (stk_rd_data)
   );

   assign req_stall = (fsm_ff != FSM_IDLE);

   always_comb begin
      fsm_in        = fsm_ff;
      cur_in        = cur_ff;
      sp_in         = sp_ff;
      flag_in       = flag_ff;
      tok_in        = tok_ff;
      steps_in      = steps_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_state_in  = rsp_state_ff;
      rsp_depth_in  = rsp_depth_ff;
      scan_start    = 1'b0;
      stk_wr_en     = 1'b0;
      advance       = 1'b0;
      push          = res.entry.ret_state != NO_RETURN;
      sp_next       = sp_ff + SP_W'(push);
      flag_eff      = req_new_program ? FIN_RUNNING : flag_ff;

      case (fsm_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               tok_in   = req_token_class;
               steps_in = '0;
               if (req_new_program) begin
                  cur_in  = START_STATE;
                  sp_in   = '0;
                  flag_in = FIN_RUNNING;
               end
               if (flag_eff != FIN_RUNNING) begin
                  status_in = ST_IGNORED;
                  fsm_in    = FSM_EMIT;
               end else begin
                  scan_start = 1'b1;
                  fsm_in     = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            if (res.done) begin
               if (!res.hit) begin
                  status_in = ST_SYNTAX;
                  flag_in   = FIN_STOPPED;
                  fsm_in    = FSM_EMIT;
               end else if (push && (sp_ff >= SP_W'(STACK_DEPTH))) begin
                  status_in = ST_OVERFLOW;
                  flag_in   = FIN_STOPPED;
                  fsm_in    = FSM_EMIT;
               end else begin
                  stk_wr_en = push;
                  if (res.entry.dst_state != EXIT_MOVE) begin
                     cur_in = res.entry.dst_state;
                     sp_in  = sp_next;
                     if (res.entry.tok != ANY_TOKEN) begin
                        status_in = ST_CONSUMED;
                        fsm_in    = FSM_EMIT;
                     end else begin
                        advance = 1'b1;
                     end
                  end else if (sp_next != '0) begin
                     sp_in  = sp_next - 1'b1;
                     fsm_in = FSM_POP;
                  end else begin
                     sp_in     = sp_next;
                     status_in = ST_ACCEPTED;
                     flag_in   = FIN_ACCEPTED;
                     fsm_in    = FSM_EMIT;
                  end
               end
            end
         end
         FSM_POP: begin
            fsm_in = FSM_LOAD;
         end
         FSM_LOAD: begin
            cur_in  = stk_rd_data;
            advance = 1'b1;
         end
         FSM_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_state_in  = cur_ff;
               rsp_depth_in  = DEPTH_W'(sp_ff);
               fsm_in        = FSM_IDLE;
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase

      if (advance) begin
         if (steps_ff == STEP_W'(MAX_EPSILON_STEPS - 1)) begin
            status_in = ST_STEPS;
            flag_in   = FIN_STOPPED;
            fsm_in    = FSM_EMIT;
         end else begin
            steps_in   = steps_ff + 1'b1;
            scan_start = 1'b1;
            fsm_in     = FSM_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         cur_ff       <= START_STATE;
         sp_ff        <= '0;
         flag_ff      <= FIN_RUNNING;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         cur_ff       <= cur_in;
         sp_ff        <= sp_in;
         flag_ff      <= flag_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff        <= tok_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_state_after = rsp_state_ff;
   assign rsp_stack_depth = rsp_depth_ff;

   a_scan_done_in_scan : assert property (@(posedge clock) disable iff (reset)
      res.done |-> fsm_ff == FSM_SCAN)
      else $error("scan result outside scan state");

   a_sp_bound : assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   a_final_sets_flag : assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == FSM_EMIT && status_ff != ST_CONSUMED && status_ff != ST_IGNORED)
      |-> flag_ff != FIN_RUNNING)
      else $error("final status without finish flag");

   a_pop_then_load : assert property (@(posedge clock) disable iff (reset)
      fsm_ff == FSM_POP |=> fsm_ff == FSM_LOAD)
      else $error("pop not followed by load");

endmodule

`default_nettype wire

/* src/pdtsc_scan.sv */
// ROM scanner: walks the transition ROM one entry a cycle through one comparator.
// Reports the first entry matching the current state and token, or a miss.
// Depends on pdtsc_pkg.
`default_nettype none

module pdtsc_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [pdtsc_pkg::STATE_W-1:0] cur_state,
   input  wire logic [pdtsc_pkg::TOKEN_W-1:0] token,
   output pdtsc_pkg::scan_res_type            res
);
   import pdtsc_pkg::*;

   logic                 busy_ff, busy_in;
   logic [ROM_IDX_W-1:0] idx_ff, idx_in;
   logic                 done_ff, done_in;
   logic                 hit_ff, hit_in;
   rom_entry_type        entry_ff, entry_in;
   rom_entry_type        cand;
   logic                 match;

   assign cand  = ROM_TABLE[idx_ff];
   assign match = (cand.src_state == cur_state) &&
                  ((cand.tok == ANY_TOKEN) || (cand.tok == {1'b0, token}));

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      done_in  = 1'b0;
      hit_in   = hit_ff;
      entry_in = entry_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff) begin
         if (match) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            hit_in   = 1'b1;
            entry_in = cand;
         end else if (idx_ff == ROM_IDX_W'(ROM_SIZE - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            hit_in  = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         hit_ff  <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         hit_ff  <= hit_in;
         idx_ff  <= idx_in;
      end
      entry_ff <= entry_in;
   end

   assign res.done  = done_ff;
   assign res.hit   = hit_ff;
   assign res.entry = entry_ff;

endmodule

`default_nettype wire

/* src/pdtsc_stack.sv */
// Return-state stack storage: one write port, one registered read port.
// Depends on pdtsc_pkg.
`default_nettype none

module pdtsc_stack #(
   parameter int STACK_DEPTH = pdtsc_pkg::DEF_STACK_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(STACK_DEPTH)-1:0]      wr_addr,
   input  wire logic [pdtsc_pkg::STATE_W-1:0]       wr_data,
   input  wire logic [$clog2(STACK_DEPTH)-1:0]      rd_addr,
   output logic      [pdtsc_pkg::STATE_W-1:0]       rd_data
);
   import pdtsc_pkg::*;

   logic [STATE_W-1:0] mem [STACK_DEPTH];
   logic [STATE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* tb/syntax_result_checker.sv */
`timescale 1ns / 1ps
// Checker for the pushdown token syntax checker: watches both channels, follows the
// automaton for every accepted token and compares each verdict field by field.
// Depends on pdtsc_pkg for the status and finish codes and the port widths.

module syntax_result_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [pdtsc_pkg::TOKEN_W-1:0]  req_token_class,
   input  wire logic                           req_new_program,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [pdtsc_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [pdtsc_pkg::STATE_W-1:0]  rsp_state_after,
   input  wire logic [pdtsc_pkg::DEPTH_W-1:0]  rsp_stack_depth,
   output int                                  mismatches,
   output int                                  awaiting
);
   import pdtsc_pkg::*;

   localparam int STACK_SIZE  = 16;
   localparam int MAX_MOVES   = 16;
   localparam int ROM_ROWS    = 70;
   localparam int WILDCARD    = 255;
   localparam int EXIT_STATE  = 0;
   localparam int NO_PUSH     = 0;
   localparam int FIRST_STATE = 1;

   typedef struct {
      status_type   status;
      logic [6:0]   state;
      logic [4:0]   depth;
   } verdict_type;

   verdict_type verdict_q [$];
   verdict_type want;
   int          grammar [0:4*ROM_ROWS-1];
   logic [6:0]  cur_state;
   logic [6:0]  return_stack [0:STACK_SIZE-1];
   int          sp;
   finish_type  progress;

   // rows of from, to, token, return
   initial grammar = '{
      1, 2, 1, 0,      1, 2, 2, 0,      2, 3, 100, 0,    3, 2, 14, 0,
      3, 1, 13, 0,     3, 4, 11, 0,     4, 10, 13, 5,    5, 6, 12, 0,
      6, 0, 255, 0,
      10, 11, 102, 0,  10, 20, 255, 12, 11, 20, 31, 12,
      12, 13, 13, 0,   13, 14, 102, 0,  13, 0, 12, 0,
      13, 0, 7, 0,     13, 20, 255, 12, 14, 20, 31, 12,
      20, 21, 100, 0,  20, 23, 9, 0,    20, 26, 10, 0,   20, 29, 3, 0,
      20, 39, 8, 0,    20, 45, 30, 0,
      21, 50, 17, 22,  22, 0, 255, 0,
      23, 24, 15, 0,   24, 25, 100, 0,  25, 24, 15, 0,
      25, 0, 255, 0,
      26, 27, 16, 0,   27, 28, 100, 0,  28, 27, 16, 0,
      28, 0, 255, 0,
      29, 30, 100, 0,  30, 50, 17, 31,  31, 50, 4, 32,   32, 50, 5, 33,
      33, 34, 6, 0,    34, 60, 28, 35,  35, 36, 29, 0,   36, 10, 13, 37,
      37, 38, 7, 0,    38, 0, 255, 0,
      39, 60, 28, 40,  40, 41, 29, 0,   41, 42, 11, 0,   42, 10, 13, 43,
      43, 44, 12, 0,   44, 0, 255, 0,
      45, 46, 102, 0,  46, 0, 255, 0,
      50, 50, 25, 0,   50, 51, 100, 0,  50, 51, 101, 0,  50, 50, 28, 52,
      51, 50, 24, 0,   51, 50, 25, 0,   51, 50, 26, 0,   51, 50, 27, 0,
      51, 0, 255, 0,   52, 51, 29, 0,
      60, 50, 255, 61, 61, 50, 20, 62,  61, 50, 18, 62,
      61, 50, 19, 62,  61, 50, 21, 62,  61, 50, 22, 62,  61, 50, 23, 62,
      62, 0, 255, 0
   };

   function automatic verdict_type verdict_here(input status_type s);
      verdict_type v;
      v.status = s;
      v.state  = cur_state;
      v.depth  = 5'(sp);
      return v;
   endfunction

   function automatic verdict_type advance_automaton(input logic [6:0] token,
                                                     input logic restart);
      int hit;
      int i;
      int step;
      int dst;
      int tok;
      int ret;
      if (restart) begin
         cur_state = 7'(FIRST_STATE);
         sp        = 0;
         progress  = FIN_RUNNING;
      end
      if (progress != FIN_RUNNING)
         return verdict_here(ST_IGNORED);
      for (step = 0; step < MAX_MOVES; step++) begin
         hit = -1;
         for (i = ROM_ROWS - 1; i >= 0; i--)
            if (grammar[4*i] == int'(cur_state) &&
                (grammar[4*i+2] == WILDCARD || grammar[4*i+2] == int'(token)))
               hit = i;
         if (hit < 0) begin
            progress = FIN_STOPPED;
            return verdict_here(ST_SYNTAX);
         end
         dst = grammar[4*hit+1];
         tok = grammar[4*hit+2];
         ret = grammar[4*hit+3];
         if (ret != NO_PUSH) begin
            if (sp >= STACK_SIZE) begin
               progress = FIN_STOPPED;
               return verdict_here(ST_OVERFLOW);
            end
            return_stack[sp] = 7'(ret);
            sp++;
         end
         if (dst != EXIT_STATE) begin
            cur_state = 7'(dst);
            if (tok != WILDCARD)
               return verdict_here(ST_CONSUMED);
         end else if (sp > 0) begin
            sp--;
            cur_state = return_stack[sp];
         end else begin
            progress = FIN_ACCEPTED;
            return verdict_here(ST_ACCEPTED);
         end
      end
      progress = FIN_STOPPED;
      return verdict_here(ST_STEPS);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cur_state  = 7'(FIRST_STATE);
         sp         = 0;
         progress   = FIN_RUNNING;
         mismatches = 0;
         verdict_q.delete();
      end else begin
         if (req_valid && !req_stall)
            verdict_q.insert(verdict_q.size(),
                             advance_automaton(req_token_class, req_new_program));
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: verdict with none due: status %0d state %0d depth %0d",
                           $realtime, rsp_status, rsp_state_after, rsp_stack_depth);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_status !== want.status || rsp_state_after !== want.state ||
                   rsp_stack_depth !== want.depth) begin
                  if (mismatches < 10)
                     $display("%0t: expected status %0d state %0d depth %0d, got %0d %0d %0d",
                              $realtime, want.status, want.state, want.depth,
                              rsp_status, rsp_state_after, rsp_stack_depth);
                  mismatches++;
               end
            end
         end
      end
      awaiting = verdict_q.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the pushdown token syntax checker: clock, reset, token programs on
// the request side, stall patterns on the result side and the final verdict.
// Depends on pdtsc_pkg, pushdown_token_syntax_checker and syntax_result_checker.

module tb_top;

   localparam int     ITEM_TARGET   = 1000;
   localparam int     HOLD_CYCLES   = 3000;
   localparam int     BLOCK_LATENCY =
      pdtsc_pkg::DEF_MAX_EPSILON_STEPS * (pdtsc_pkg::ROM_SIZE + 3) + 2;
   localparam longint RUN_LIMIT_NS  = 64'd60_000_000;

   localparam int TK_PROGRAM  = 1;
   localparam int TK_MODULE   = 2;
   localparam int TK_FOR      = 3;
   localparam int TK_FOR_TO   = 4;
   localparam int TK_FOR_STEP = 5;
   localparam int TK_FOR_DO   = 6;
   localparam int TK_NEXT     = 7;
   localparam int TK_WHILE    = 8;
   localparam int TK_LIST_A   = 9;
   localparam int TK_LIST_B   = 10;
   localparam int TK_BEGIN    = 11;
   localparam int TK_END      = 12;
   localparam int TK_SEMI     = 13;
   localparam int TK_COMMA    = 14;
   localparam int TK_SEP_A    = 15;
   localparam int TK_SEP_B    = 16;
   localparam int TK_ASSIGN   = 17;
   localparam int TK_REL_LO   = 18;
   localparam int TK_REL_HI   = 23;
   localparam int TK_OP_LO    = 24;
   localparam int TK_MINUS    = 25;
   localparam int TK_OP_HI    = 27;
   localparam int TK_LPAREN   = 28;
   localparam int TK_RPAREN   = 29;
   localparam int TK_GOTO     = 30;
   localparam int TK_COLON    = 31;
   localparam int TK_IDENT    = 100;
   localparam int TK_CONST    = 101;
   localparam int TK_LABEL    = 102;
   localparam int TK_TOP      = 127;

   localparam int SYM_EXPR  = 200;
   localparam int SYM_TERM  = 201;
   localparam int SYM_COND  = 202;
   localparam int SYM_STMT  = 203;
   localparam int SYM_BLOCK = 204;

   localparam int STALL_NEVER    = 0;
   localparam int STALL_SOME     = 1;
   localparam int STALL_MOST     = 2;
   localparam int STALL_PERIODIC = 3;

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_stall;
   logic [pdtsc_pkg::TOKEN_W-1:0]     req_token_class = '0;
   logic                              req_new_program = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall       = 1'b0;
   logic [pdtsc_pkg::STATUS_W-1:0]    rsp_status;
   logic [pdtsc_pkg::STATE_W-1:0]     rsp_state_after;
   logic [pdtsc_pkg::DEPTH_W-1:0]     rsp_stack_depth;

   int         mismatches;
   int         awaiting;
   int         hold_asks   = 0;
   int         burst_left  = 0;
   int         items_sent  = 0;
   logic [6:0] prog_tokens [$];

   pushdown_token_syntax_checker i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_token_class (req_token_class),
      .req_new_program (req_new_program),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_state_after (rsp_state_after),
      .rsp_stack_depth (rsp_stack_depth)
   );

   syntax_result_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_token_class (req_token_class),
      .req_new_program (req_new_program),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_state_after (rsp_state_after),
      .rsp_stack_depth (rsp_stack_depth),
      .mismatches      (mismatches),
      .awaiting        (awaiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int mode;
      int mode_left;
      int served;
      mode      = STALL_NEVER;
      mode_left = 0;
      served    = 0;
      forever begin
         @(posedge clock);
         if (served != hold_asks) begin
            served = hold_asks;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(STALL_NEVER, STALL_PERIODIC);
               mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (mode)
               STALL_NEVER: rsp_stall <= 1'b0;
               STALL_SOME:  rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_MOST:  rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ((mode_left % 7) < 3);
            endcase
         end
      end
   end

   task automatic send_token(input logic [6:0] tok, input logic restart);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_token_class <= tok;
      req_new_program <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      burst_left = 0;
   endtask

   task automatic play_program(input logic restart_first, input int restart_at);
      int i;
      for (i = 0; i < prog_tokens.size(); i++)
         send_token(prog_tokens[i], (i == 0 && restart_first) || i == restart_at);
   endtask

   task automatic append_token(input int t);
      prog_tokens.insert(prog_tokens.size(), 7'(t));
   endtask

   // expand the grammar leftmost-first from a work list; nesting is bounded by its size and the program length
   task automatic build_program();
      int   work [$];
      int   seq [$];
      int   sym;
      int   n;
      int   pick;
      int   i;
      logic roomy;
      logic more;
      prog_tokens.delete();
      do begin
         append_token($urandom_range(0, 1) ? TK_PROGRAM : TK_MODULE);
         append_token(TK_IDENT);
         repeat ($urandom_range(0, 2)) begin
            append_token(TK_COMMA);
            append_token(TK_IDENT);
         end
         more = ($urandom_range(0, 3) == 0);
         if (more)
            append_token(TK_SEMI);
      end while (more);
      append_token(TK_BEGIN);
      append_token(TK_SEMI);
      work.insert(work.size(), SYM_BLOCK);
      while (work.size() > 0) begin
         sym = work.pop_front();
         if (sym < SYM_EXPR) begin
            append_token(sym);
         end else begin
            seq.delete();
            roomy = (work.size() < 24) && (prog_tokens.size() < 120);
            case (sym)
               SYM_EXPR: begin
                  seq.insert(seq.size(), SYM_TERM);
                  repeat ($urandom_range(0, 2)) begin
                     seq.insert(seq.size(), $urandom_range(TK_OP_LO, TK_OP_HI));
                     seq.insert(seq.size(), SYM_TERM);
                  end
               end
               SYM_TERM: begin
                  if ($urandom_range(0, 4) == 0) begin
                     seq.insert(seq.size(), TK_MINUS);
                     seq.insert(seq.size(), SYM_TERM);
                  end else if (roomy && $urandom_range(0, 3) == 0) begin
                     seq.insert(seq.size(), TK_LPAREN);
                     seq.insert(seq.size(), SYM_EXPR);
                     seq.insert(seq.size(), TK_RPAREN);
                  end else begin
                     seq.insert(seq.size(), $urandom_range(0, 1) ? TK_IDENT : TK_CONST);
                  end
               end
               SYM_COND: begin
                  seq.insert(seq.size(), SYM_EXPR);
                  seq.insert(seq.size(), $urandom_range(TK_REL_LO, TK_REL_HI));
                  seq.insert(seq.size(), SYM_EXPR);
               end
               SYM_STMT: begin
                  pick = $urandom_range(0, roomy ? 5 : 3);
                  case (pick)
                     0: seq = '{TK_IDENT, TK_ASSIGN, SYM_EXPR};
                     1, 2: begin
                        seq.insert(seq.size(), pick == 1 ? TK_LIST_A : TK_LIST_B);
                        n = $urandom_range(1, 3);
                        repeat (n) begin
                           seq.insert(seq.size(), pick == 1 ? TK_SEP_A : TK_SEP_B);
                           seq.insert(seq.size(), TK_IDENT);
                        end
                     end
                     3: seq = '{TK_GOTO, TK_LABEL};
                     4: seq = '{TK_FOR, TK_IDENT, TK_ASSIGN, SYM_EXPR, TK_FOR_TO, SYM_EXPR,
                                TK_FOR_STEP, SYM_EXPR, TK_FOR_DO, TK_LPAREN, SYM_COND,
                                TK_RPAREN, TK_SEMI, SYM_BLOCK, TK_NEXT};
                     default: seq = '{TK_WHILE, TK_LPAREN, SYM_COND, TK_RPAREN, TK_BEGIN,
                                      TK_SEMI, SYM_BLOCK, TK_END};
                  endcase
               end
               default: begin
                  n = $urandom_range(1, 3);
                  repeat (n) begin
                     if ($urandom_range(0, 3) == 0) begin
                        seq.insert(seq.size(), TK_LABEL);
                        seq.insert(seq.size(), TK_COLON);
                     end
                     seq.insert(seq.size(), SYM_STMT);
                     seq.insert(seq.size(), TK_SEMI);
                  end
               end
            endcase
            for (i = seq.size() - 1; i >= 0; i--)
               work.push_front(seq[i]);
         end
      end
      append_token(TK_END);
      append_token($urandom_range(0, TK_TOP));
   endtask

   initial begin
      int prog_no;
      int k;
      int cut;
      int restart_at;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // minimal program straight from reset, then a token after acceptance
      prog_tokens = '{7'(TK_PROGRAM), 7'(TK_IDENT), 7'(TK_BEGIN), 7'(TK_SEMI), 7'(TK_GOTO),
                      7'(TK_LABEL), 7'(TK_SEMI), 7'(TK_END), 7'(TK_TOP), 7'd0};
      play_program(1'b0, -1);
      send_token(7'd0, 1'b1);
      // nested parentheses until the return stack overflows
      prog_tokens = '{7'(TK_MODULE), 7'(TK_IDENT), 7'(TK_BEGIN), 7'(TK_SEMI), 7'(TK_WHILE)};
      repeat (14) append_token(TK_LPAREN);
      play_program(1'b1, -1);
      pause_until_drained();

      prog_no = 0;
      while (items_sent < ITEM_TARGET) begin
         build_program();
         if ($urandom_range(0, 3) == 0) begin
            k = $urandom_range(0, prog_tokens.size() - 1);
            prog_tokens[k] = 7'($urandom_range(0, TK_TOP));
            cut = k + 1 + $urandom_range(0, 2);
            while (prog_tokens.size() > cut) prog_tokens.delete(prog_tokens.size() - 1);
         end
         restart_at = -1;
         if (prog_tokens.size() > 1 && $urandom_range(0, 7) == 0)
            restart_at = $urandom_range(1, prog_tokens.size() - 1);
         if (prog_no == 2 || prog_no == 9)
            hold_asks++;
         play_program(1'b1, restart_at);
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4))
               send_token(7'($urandom_range(0, TK_TOP)), 1'($urandom_range(0, 1)));
         if (prog_no % 5 == 4)
            pause_until_drained();
         prog_no++;
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (awaiting != 0);
      repeat (BLOCK_LATENCY) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
